### sv/vcsd_pkg.sv
`default_nettype none

package vcsd_pkg;

   // Frame identifiers that carry kept signals.
   localparam logic [10:0] ID_DISPLAY = 11'h713;
   localparam logic [10:0] ID_BATT48  = 11'h580;
   localparam logic [10:0] ID_ODO     = 11'h581;
   localparam logic [10:0] ID_CHARGE  = 11'h582;
   localparam logic [10:0] ID_BATT12  = 11'h593;

   // Reset values of the kept signals.
   localparam logic [1:0] GEAR_UNKNOWN = 2'd3;
   localparam logic       BRAKE_RESET  = 1'b1;

   // Divide-by-ten unit: the magnitude is scaled by about 0.8 through a chain
   // of shifted additions, one per cycle, divided by eight, and then corrected
   // once from the remainder.
   localparam int                   NUM_W     = 36;
   localparam int                   DIV_STEPS = 7;
   localparam int                   DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [NUM_W-1:0]     DIVISOR   = NUM_W'(10);

   localparam logic [DIV_CNT_W-1:0] STEP_SEED   = DIV_CNT_W'(0);
   localparam logic [DIV_CNT_W-1:0] STEP_FOLD4  = DIV_CNT_W'(1);
   localparam logic [DIV_CNT_W-1:0] STEP_FOLD8  = DIV_CNT_W'(2);
   localparam logic [DIV_CNT_W-1:0] STEP_FOLD16 = DIV_CNT_W'(3);
   localparam logic [DIV_CNT_W-1:0] STEP_FOLD32 = DIV_CNT_W'(4);
   localparam logic [DIV_CNT_W-1:0] STEP_REM    = DIV_CNT_W'(5);
   localparam logic [DIV_CNT_W-1:0] STEP_ROUND  = DIV_CNT_W'(6);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DEC  = 6'b000010,
      ST_SUM  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_EMIT = 6'b100000
   } vcsd_state_type;

   typedef struct packed {
      logic                 capture;
      logic                 decode;
      logic                 sum_load;
      logic                 div_step;
      logic [DIV_CNT_W-1:0] div_sel;
      logic                 fin_apply;
      logic                 out_load;
   } vcsd_cmd_type;

   typedef struct packed {
      logic is_batt;
   } vcsd_stat_type;

endpackage

`default_nettype wire

### sv/vcsd_ctrl.sv
`default_nettype none

module vcsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  vcsd_pkg::vcsd_stat_type stat,
   output vcsd_pkg::vcsd_cmd_type  cmd
);
   import vcsd_pkg::*;

   vcsd_state_type       state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 valid_ff, valid_in;
   logic                 out_free;

   // The result register can take a new snapshot once the old one is gone.
   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DEC;
            end
         end
         ST_DEC: begin
            cmd.decode = 1'b1;
            state_in   = stat.is_batt ? ST_SUM : ST_EMIT;
         end
         ST_SUM: begin
            cmd.sum_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = cnt_ff;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            cmd.fin_apply = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

### sv/vcsd_dp.sv
`default_nettype none

module vcsd_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  vcsd_pkg::vcsd_cmd_type  cmd,
   output vcsd_pkg::vcsd_stat_type stat,
   input  logic                    req_kind,
   input  logic [10:0]             req_frame_id,
   input  logic                    req_is_remote,
   input  logic [63:0]             req_payload,
   output logic [1:0]              rsp_gear_code,
   output logic [6:0]              rsp_range_left,
   output logic                    rsp_drive_ready,
   output logic                    rsp_brake_set,
   output logic [7:0]              rsp_charge_level,
   output logic [7:0]              rsp_speed_now,
   output logic [23:0]             rsp_distance_total,
   output logic [15:0]             rsp_charge_minutes,
   output logic [15:0]             rsp_aux_volts,
   output logic signed [31:0]      rsp_power_smooth,
   output logic [30:0]             rsp_power_peak_high,
   output logic signed [30:0]      rsp_power_peak_low
);
   import vcsd_pkg::*;

   localparam int LANE_POW  = 0;
   localparam int LANE_PEAK = 1;
   localparam int LANES     = 2;

   // Latched transaction.
   logic        kind_ff, remote_ff;
   logic [10:0] id_ff;
   logic [63:0] payload_ff;

   // Kept vehicle signals.
   logic [1:0]         gear_ff, gear_in;
   logic [6:0]         range_ff, range_in;
   logic               ready_ff, ready_in;
   logic               brake_ff, brake_in;
   logic [7:0]         soc_ff, soc_in;
   logic [23:0]        odo_ff, odo_in;
   logic [7:0]         speed_ff, speed_in;
   logic [15:0]        remain_ff, remain_in;
   logic [15:0]        aux_ff, aux_in;
   logic signed [31:0] power_ff, power_in;
   logic [30:0]        high_ff, high_in;
   logic signed [30:0] low_ff, low_in;

   // Power arithmetic.
   logic signed [31:0] pw_ff;
   logic signed [15:0] amps, volts;
   logic signed [NUM_W-1:0] pow_ext, pw_ext, n_pow, n_peak;
   logic [NUM_W-1:0] num_ff [LANES];
   logic [NUM_W-1:0] num_in [LANES];
   logic [NUM_W-1:0] quo_ff [LANES];
   logic [NUM_W-1:0] quo_in [LANES];
   logic             neg_ff [LANES];
   logic signed [31:0] q_pow, q_peak;

   logic [6:0] out_range;
   logic       out_ready, out_brake;
   logic [7:0] out_soc, out_speed;
   logic [23:0] out_odo;
   logic [15:0] out_remain, out_aux;
   logic signed [31:0] out_power;
   logic [30:0] out_high;
   logic signed [30:0] out_low;

   assign stat.is_batt = !kind_ff && !remote_ff && (id_ff == ID_BATT48);

   assign amps  = payload_ff[15:0];
   assign volts = payload_ff[31:16];

   assign pow_ext = NUM_W'(power_ff);
   assign pw_ext  = NUM_W'(pw_ff);
   assign n_peak  = (pow_ext <<< 1) + pow_ext + (pw_ext <<< 3) - pw_ext;
   assign n_pow   = (pow_ext <<< 2) + (pow_ext <<< 1) + (pw_ext <<< 2);

   // Quotients carry at most 31 magnitude bits; the sign is put back here
   // so that the division truncates toward zero.
   assign q_pow  = neg_ff[LANE_POW]  ? -$signed(quo_ff[LANE_POW][31:0])
                                     :  $signed(quo_ff[LANE_POW][31:0]);
   assign q_peak = neg_ff[LANE_PEAK] ? -$signed(quo_ff[LANE_PEAK][31:0])
                                     :  $signed(quo_ff[LANE_PEAK][31:0]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         id_ff      <= req_frame_id;
         remote_ff  <= req_is_remote;
         payload_ff <= req_payload;
      end
      if (cmd.decode) begin
         pw_ff <= amps * volts;
      end
   end

   // Divider lanes: one shifted addition per step approximates n * 0.8, the
   // result is divided by eight, and the remainder decides a final increment.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num_in[l] = num_ff[l];
         quo_in[l] = quo_ff[l];
         unique case (cmd.div_sel)
            STEP_SEED: begin
               quo_in[l] = (num_ff[l] >> 1) + (num_ff[l] >> 2);
            end
            STEP_FOLD4: begin
               quo_in[l] = quo_ff[l] + (quo_ff[l] >> 4);
            end
            STEP_FOLD8: begin
               quo_in[l] = quo_ff[l] + (quo_ff[l] >> 8);
            end
            STEP_FOLD16: begin
               quo_in[l] = quo_ff[l] + (quo_ff[l] >> 16);
            end
            STEP_FOLD32: begin
               quo_in[l] = (quo_ff[l] + (quo_ff[l] >> 32)) >> 3;
            end
            STEP_REM: begin
               num_in[l] = num_ff[l] - ((quo_ff[l] << 3) + (quo_ff[l] << 1));
            end
            STEP_ROUND: begin
               quo_in[l] = quo_ff[l] + NUM_W'(num_ff[l] >= DIVISOR);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_load) begin
         neg_ff[LANE_POW]  <= n_pow[NUM_W-1];
         neg_ff[LANE_PEAK] <= n_peak[NUM_W-1];
         num_ff[LANE_POW]  <= n_pow[NUM_W-1] ? -n_pow : n_pow;
         num_ff[LANE_PEAK] <= n_peak[NUM_W-1] ? -n_peak : n_peak;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         quo_ff <= quo_in;
      end
   end

   always_comb begin
      gear_in   = gear_ff;
      range_in  = range_ff;
      ready_in  = ready_ff;
      brake_in  = brake_ff;
      soc_in    = soc_ff;
      odo_in    = odo_ff;
      speed_in  = speed_ff;
      remain_in = remain_ff;
      aux_in    = aux_ff;
      power_in  = power_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      if (cmd.decode) begin
         if (kind_ff) begin
            gear_in   = GEAR_UNKNOWN;
            range_in  = '0;
            ready_in  = 1'b0;
            brake_in  = BRAKE_RESET;
            soc_in    = '0;
            odo_in    = '0;
            speed_in  = '0;
            remain_in = '0;
            aux_in    = '0;
            power_in  = '0;
            high_in   = '0;
            low_in    = '0;
         end else if (!remote_ff) begin
            unique case (id_ff)
               ID_DISPLAY: begin
                  gear_in  = {payload_ff[8], payload_ff[7]};
                  range_in = payload_ff[6:0];
                  ready_in = payload_ff[18];
                  brake_in = payload_ff[29];
               end
               ID_ODO: begin
                  odo_in   = payload_ff[55:32];
                  speed_in = payload_ff[63:56];
               end
               ID_CHARGE: begin
                  remain_in = payload_ff[15:0];
               end
               ID_BATT12: begin
                  aux_in = payload_ff[15:0];
               end
               default: begin
               end
            endcase
         end
      end
      if (cmd.fin_apply) begin
         power_in = q_pow;
         soc_in   = payload_ff[47:40];
         if (q_peak > $signed({1'b0, high_ff})) begin
            high_in = q_peak[30:0];
         end
         if (q_peak < $signed({low_ff[30], low_ff})) begin
            low_in = q_peak[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff   <= GEAR_UNKNOWN;
         range_ff  <= '0;
         ready_ff  <= 1'b0;
         brake_ff  <= BRAKE_RESET;
         soc_ff    <= '0;
         odo_ff    <= '0;
         speed_ff  <= '0;
         remain_ff <= '0;
         aux_ff    <= '0;
         power_ff  <= '0;
         high_ff   <= '0;
         low_ff    <= '0;
      end else begin
         gear_ff   <= gear_in;
         range_ff  <= range_in;
         ready_ff  <= ready_in;
         brake_ff  <= brake_in;
         soc_ff    <= soc_in;
         odo_ff    <= odo_in;
         speed_ff  <= speed_in;
         remain_ff <= remain_in;
         aux_ff    <= aux_in;
         power_ff  <= power_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
      end
   end

   // Snapshot register that feeds the result channel.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_range      <= range_ff;
         out_ready      <= ready_ff;
         out_brake      <= brake_ff;
         out_soc        <= soc_ff;
         out_speed      <= speed_ff;
         out_odo        <= odo_ff;
         out_remain     <= remain_ff;
         out_aux        <= aux_ff;
         out_power      <= power_ff;
         out_high       <= high_ff;
         out_low        <= low_ff;
         rsp_gear_code  <= gear_ff;
      end
   end

   assign rsp_range_left      = out_range;
   assign rsp_drive_ready     = out_ready;
   assign rsp_brake_set       = out_brake;
   assign rsp_charge_level    = out_soc;
   assign rsp_speed_now       = out_speed;
   assign rsp_distance_total  = out_odo;
   assign rsp_charge_minutes  = out_remain;
   assign rsp_aux_volts       = out_aux;
   assign rsp_power_smooth    = out_power;
   assign rsp_power_peak_high = out_high;
   assign rsp_power_peak_low  = out_low;

endmodule

`default_nettype wire

### sv/vehicle_can_signal_decoder_core.sv
`default_nettype none

// Decodes received CAN frames into a set of kept vehicle signals and returns
// one snapshot of all signals for every request transaction. A request is
// either a received frame (kind 0), selected by its identifier, or a clear
// event (kind 1) that restores the reset values; remote frames and unknown
// identifiers leave the signals as they are. Battery frames (0x580) form
// power in milliwatts as current times voltage, set the charge level and
// update the smoothed power and the peak extremes, both divided by ten with
// truncation toward zero. A new request is taken only once the previous one
// is through, which for battery frames means a multiply stage, a sum stage,
// a divide-by-ten unit of shifted additions and one correction, and an
// update stage. The snapshot sits in an output register, so a new request
// can be taken while the previous response is still stalled; its snapshot
// then waits until that response has been taken.

module vehicle_can_signal_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [10:0]        req_frame_id,
   input  logic               req_is_remote,
   input  logic [63:0]        req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_gear_code,
   output logic [6:0]         rsp_range_left,
   output logic               rsp_drive_ready,
   output logic               rsp_brake_set,
   output logic [7:0]         rsp_charge_level,
   output logic [7:0]         rsp_speed_now,
   output logic [23:0]        rsp_distance_total,
   output logic [15:0]        rsp_charge_minutes,
   output logic [15:0]        rsp_aux_volts,
   output logic signed [31:0] rsp_power_smooth,
   output logic [30:0]        rsp_power_peak_high,
   output logic signed [30:0] rsp_power_peak_low
);
   import vcsd_pkg::*;

   vcsd_cmd_type  cmd;
   vcsd_stat_type stat;

   vcsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   vcsd_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_kind),
      .req_frame_id        (req_frame_id),
      .req_is_remote       (req_is_remote),
      .req_payload         (req_payload),
      .rsp_gear_code       (rsp_gear_code),
      .rsp_range_left      (rsp_range_left),
      .rsp_drive_ready     (rsp_drive_ready),
      .rsp_brake_set       (rsp_brake_set),
      .rsp_charge_level    (rsp_charge_level),
      .rsp_speed_now       (rsp_speed_now),
      .rsp_distance_total  (rsp_distance_total),
      .rsp_charge_minutes  (rsp_charge_minutes),
      .rsp_aux_volts       (rsp_aux_volts),
      .rsp_power_smooth    (rsp_power_smooth),
      .rsp_power_peak_high (rsp_power_peak_high),
      .rsp_power_peak_low  (rsp_power_peak_low)
   );

endmodule

`default_nettype wire
